>>> design/tdhs_pkg.sv
// ----------------------------------------------------------------------------
// tdhs_pkg
// shared types, month codes and calendar helpers for the date/hour shifter
// ----------------------------------------------------------------------------
package tdhs_pkg;

   localparam int YearWidth   = 14;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int OffsetWidth = 5;

   localparam int HoursPerDay   = 24;
   localparam int MonthsPerYear = 12;

   // month codes
   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthMar = 4'd3;
   localparam logic [MonthWidth-1:0] MonthMay = 4'd5;
   localparam logic [MonthWidth-1:0] MonthJul = 4'd7;
   localparam logic [MonthWidth-1:0] MonthAug = 4'd8;
   localparam logic [MonthWidth-1:0] MonthOct = 4'd10;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;
   localparam logic [MonthWidth-1:0] MonthNone = 4'd0;

   localparam logic [DayWidth-1:0] DaysLong     = 5'd31;
   localparam logic [DayWidth-1:0] DaysShort    = 5'd30;
   localparam logic [DayWidth-1:0] DaysFebLeap  = 5'd29;
   localparam logic [DayWidth-1:0] DaysFebPlain = 5'd28;

   // divisibility by 25 on a 12-bit value: multiply by the inverse of 25
   // modulo 2^12 and compare against floor((2^12 - 1) / 25)
   localparam int Div25Width = 12;
   localparam logic [Div25Width-1:0] Div25Inverse = 12'd3113;
   localparam logic [Div25Width-1:0] Div25Limit   = 12'((2 ** Div25Width - 1) / 25);

   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
      logic [HourWidth-1:0]  hour;
   } date_type;

   function automatic logic div_by_25(input logic [Div25Width-1:0] value);
      logic [Div25Width-1:0] prod;
      prod = Div25Width'(value * Div25Inverse);
      return prod <= Div25Limit;
   endfunction

   // leap when divisible by 4 and not 100, or by 400 and not 3200
   function automatic logic is_leap(input logic [YearWidth-1:0] year);
      logic div4;
      logic div100;
      logic div400;
      logic div3200;
      div4    = (year[1:0] == 2'd0);
      div100  = div4 && div_by_25(year[13:2]);
      div400  = (year[3:0] == 4'd0) && div_by_25({2'b00, year[13:4]});
      div3200 = (year[6:0] == 7'd0) && div_by_25({5'b00000, year[13:7]});
      return (div4 && !div100) || (div400 && !div3200);
   endfunction

   function automatic logic [DayWidth-1:0] month_length(input logic [YearWidth-1:0]  year,
                                                        input logic [MonthWidth-1:0] month);
      logic [DayWidth-1:0] len;
      case (month)
         MonthFeb: len = is_leap(year) ? DaysFebLeap : DaysFebPlain;
         MonthJan, MonthMar, MonthMay, MonthJul,
         MonthAug, MonthOct, MonthDec: len = DaysLong;
         default: len = DaysShort;
      endcase
      return len;
   endfunction

endpackage

>>> design/tdhs_calc.sv
// ----------------------------------------------------------------------------
// tdhs_calc
// applies the hour offset and carries or borrows through day, month and year
// ----------------------------------------------------------------------------
module tdhs_calc (
   input  tdhs_pkg::date_type                       date_i,
   input  logic signed [tdhs_pkg::OffsetWidth-1:0]  offset_i,
   output tdhs_pkg::date_type                       date_o
);

   logic signed [6:0] hour_sum;
   logic signed [6:0] day_step;
   logic signed [6:0] day_fix;
   logic signed [6:0] cur_len;
   logic signed [6:0] prev_len;
   logic signed [5:0] month_step;
   logic signed [5:0] month_fix;
   logic [tdhs_pkg::YearWidth-1:0] year_fix;
   logic [tdhs_pkg::HourWidth-1:0] hour_fix;
   logic [tdhs_pkg::DayWidth-1:0]  len_now;
   logic [tdhs_pkg::DayWidth-1:0]  len_prev;

   always_comb begin
      len_now = tdhs_pkg::month_length(date_i.year, date_i.month);

      // previous month length, month 0 steps back to a 30-day code
      if (date_i.month == tdhs_pkg::MonthJan) begin
         len_prev = tdhs_pkg::DaysLong;
      end else if (date_i.month == tdhs_pkg::MonthNone) begin
         len_prev = tdhs_pkg::DaysShort;
      end else begin
         len_prev = tdhs_pkg::month_length(date_i.year, date_i.month - 4'd1);
      end
      cur_len  = $signed({2'b00, len_now});
      prev_len = $signed({2'b00, len_prev});

      // hour step
      hour_sum = $signed({2'b00, date_i.hour}) + $signed({{2{offset_i[4]}}, offset_i});
      day_step = $signed({2'b00, date_i.day});
      if (hour_sum >= $signed(7'(tdhs_pkg::HoursPerDay))) begin
         hour_fix = hour_sum[4:0] - 5'(tdhs_pkg::HoursPerDay);
         day_step = day_step + 7'sd1;
      end else if (hour_sum < 7'sd0) begin
         hour_fix = hour_sum[4:0] + 5'(tdhs_pkg::HoursPerDay);
         day_step = day_step - 7'sd1;
      end else begin
         hour_fix = hour_sum[4:0];
      end

      // day step
      month_step = $signed({2'b00, date_i.month});
      day_fix    = day_step;
      if (day_step > cur_len) begin
         day_fix    = day_step - cur_len;
         month_step = month_step + 6'sd1;
      end else if (day_step <= 7'sd0) begin
         day_fix    = day_step + prev_len;
         month_step = month_step - 6'sd1;
      end

      // month step, year wraps modulo 2^14
      month_fix = month_step;
      year_fix  = date_i.year;
      if (month_step > $signed(6'(tdhs_pkg::MonthsPerYear))) begin
         month_fix = month_step - 6'(tdhs_pkg::MonthsPerYear);
         year_fix  = date_i.year + 14'd1;
      end else if (month_step <= 6'sd0) begin
         month_fix = month_step + 6'(tdhs_pkg::MonthsPerYear);
         year_fix  = date_i.year - 14'd1;
      end

      date_o.year  = year_fix;
      date_o.month = month_fix[3:0];
      date_o.day   = day_fix[4:0];
      date_o.hour  = hour_fix;
   end

endmodule

>>> design/timezone_date_hour_shift_unit.sv
// path: an accepted req beat passes through the input register, then the result register, to its rsp beat
// throughput: one beat per cycle while rsp_stall is low, set by the single
//   calendar pass between the input register and the result register
// reset: synchronous, active high; clears both valid flags and sets the
//   timezone offset to zero
// ----------------------------------------------------------------------------
// timezone_date_hour_shift_unit
// adds a signed whole-hour offset to a date and hour, carrying into the date
// ----------------------------------------------------------------------------
module timezone_date_hour_shift_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic signed [tdhs_pkg::OffsetWidth-1:0]   csr_tz_offset_hours,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [tdhs_pkg::YearWidth-1:0]            req_year_in,
   input  logic [tdhs_pkg::MonthWidth-1:0]           req_month_in,
   input  logic [tdhs_pkg::DayWidth-1:0]             req_day_in,
   input  logic [tdhs_pkg::HourWidth-1:0]            req_hour_in,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [tdhs_pkg::YearWidth-1:0]            rsp_year_out,
   output logic [tdhs_pkg::MonthWidth-1:0]           rsp_month_out,
   output logic [tdhs_pkg::DayWidth-1:0]             rsp_day_out,
   output logic [tdhs_pkg::HourWidth-1:0]            rsp_hour_out
);

   // offset register
   logic signed [tdhs_pkg::OffsetWidth-1:0] offset_ff;
   logic signed [tdhs_pkg::OffsetWidth-1:0] offset_in;

   // input stage
   logic               in_valid_ff;
   logic               in_valid_in;
   tdhs_pkg::date_type in_date_ff;
   tdhs_pkg::date_type in_date_in;

   // result stage
   logic               out_valid_ff;
   logic               out_valid_in;
   tdhs_pkg::date_type out_date_ff;
   tdhs_pkg::date_type out_date_in;

   tdhs_pkg::date_type calc_date;
   logic               out_free;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // the result stage can load when empty or when its beat leaves this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // input stage holds only when it is full and the result stage is blocked
   assign req_stall = in_valid_ff && !out_free;

   tdhs_calc u_calc (
      .date_i   (in_date_ff),
      .offset_i (offset_ff),
      .date_o   (calc_date)
   );

   always_comb begin
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         offset_in = csr_tz_offset_hours;
      end

      // input stage: take a new beat whenever not stalled
      in_valid_in = in_valid_ff;
      in_date_in  = in_date_ff;
      if (!req_stall) begin
         in_valid_in      = req_valid;
         in_date_in.year  = req_year_in;
         in_date_in.month = req_month_in;
         in_date_in.day   = req_day_in;
         in_date_in.hour  = req_hour_in;
      end

      // result stage: capture the shifted date as it moves forward
      out_valid_in = out_valid_ff;
      out_date_in  = out_date_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_date_in  = calc_date;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_date_ff  <= in_date_in;
      out_date_ff <= out_date_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_year_out  = out_date_ff.year;
   assign rsp_month_out = out_date_ff.month;
   assign rsp_day_out   = out_date_ff.day;
   assign rsp_hour_out  = out_date_ff.hour;

endmodule

>>> design/tdhs_checker.sv
// ----------------------------------------------------------------------------
// tdhs_checker
// port-level checks on the date/hour shifter, bound to the top level
// ----------------------------------------------------------------------------
module tdhs_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic [tdhs_pkg::YearWidth-1:0]            rsp_year_out,
   input logic [tdhs_pkg::MonthWidth-1:0]           rsp_month_out,
   input logic [tdhs_pkg::DayWidth-1:0]             rsp_day_out,
   input logic [tdhs_pkg::HourWidth-1:0]            rsp_hour_out
);

   // a stalled rsp beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year_out)
         && $stable(rsp_month_out) && $stable(rsp_day_out) && $stable(rsp_hour_out))
      else $error("stalled rsp beat changed");

   // hour carry always lands inside one day
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour_out < 5'(tdhs_pkg::HoursPerDay))
      else $error("rsp hour out of range");

   // month carry or borrow always lands on a real month
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_out != tdhs_pkg::MonthNone
         && rsp_month_out <= 4'(tdhs_pkg::MonthsPerYear))
      else $error("rsp month out of range");

   // a day borrow never leaves day zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_out != 5'd0)
      else $error("rsp day is zero");

endmodule

bind timezone_date_hour_shift_unit tdhs_checker u_tdhs_checker (.*);
